### sv/dtc_pkg.sv
// ----------------------------------------------------------------------------
// dtc_pkg
// Types and constants shared by the decision tree classifier modules.
// ----------------------------------------------------------------------------
package dtc_pkg;

  localparam int NODES    = 256;
  localparam int FEATURES = 64;
  localparam int CLASSES  = 16;

  localparam int NODE_W  = $clog2(NODES);
  localparam int FEAT_W  = $clog2(FEATURES);
  localparam int CLASS_W = $clog2(CLASSES);
  localparam int HIST_W  = NODE_W + CLASS_W;

  localparam logic [16:0] PROB_ONE = 17'd65536;

  // configuration register indexes
  localparam logic [1:0] CFG_NUM_CLASSES = 2'd0;
  localparam logic [1:0] CFG_ROOT_NODE   = 2'd1;
  localparam logic [1:0] CFG_DEPTH_LIMIT = 2'd2;

  typedef enum logic [1:0] {
    MODE_NODE     = 2'd0,
    MODE_LEAF     = 2'd1,
    MODE_FEAT     = 2'd2,
    MODE_CLASSIFY = 2'd3
  } dtc_mode_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_NODE,
    ST_CMP,
    ST_EMIT,
    ST_ERR
  } dtc_state_e;

  typedef struct packed {
    logic [1:0]         mode;
    logic [7:0]         node_addr;
    logic [5:0]         split_feature;
    logic signed [31:0] split_threshold;
    logic               is_leaf;
    logic [7:0]         left_child;
    logic [7:0]         right_child;
    logic [5:0]         slot;
    logic signed [31:0] sample_value;
  } dtc_in_item_t;

  typedef struct packed {
    logic [3:0]  class_index;
    logic [16:0] probability;
    logic [7:0]  leaf_node;
    logic        status;
    logic        last;
  } dtc_out_item_t;

  // one node table entry, 55 bits
  typedef struct packed {
    logic [5:0]  feat;
    logic [31:0] thr;
    logic        leaf;
    logic [7:0]  left;
    logic [7:0]  right;
  } dtc_node_t;

  typedef struct packed {
    logic wr_node;
    logic wr_leaf;
    logic wr_feat;
    logic start_walk;
    logic take_step;
    logic emit_class;
    logic emit_error;
  } dtc_cmd_t;

  typedef struct packed {
    logic node_leaf;
    logic depth_hit;
    logic class_last;
    logic out_free;
  } dtc_stat_t;

endpackage

### sv/dtc_in_if.sv
// ----------------------------------------------------------------------------
// dtc_in_if
// Valid/ready channel carrying one input item.
// ----------------------------------------------------------------------------
interface dtc_in_if
  import dtc_pkg::*;
;
  logic         valid;
  logic         ready;
  dtc_in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### sv/dtc_out_if.sv
// ----------------------------------------------------------------------------
// dtc_out_if
// Valid/ready channel carrying one result item.
// ----------------------------------------------------------------------------
interface dtc_out_if
  import dtc_pkg::*;
;
  logic          valid;
  logic          ready;
  dtc_out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### sv/dtc_ctrl.sv
// ----------------------------------------------------------------------------
// dtc_ctrl
// Sequencer: decodes input items, steps the tree walk and paces emission.
// ----------------------------------------------------------------------------
module dtc_ctrl
  import dtc_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic [1:0] in_mode_i,
  output logic       in_ready_o,
  input  dtc_stat_t  stat_i,
  output dtc_cmd_t   cmd_o
);

  dtc_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          unique case (dtc_mode_e'(in_mode_i))
            MODE_NODE: cmd_o.wr_node = 1'b1;
            MODE_LEAF: cmd_o.wr_leaf = 1'b1;
            MODE_FEAT: cmd_o.wr_feat = 1'b1;
            MODE_CLASSIFY: begin
              cmd_o.start_walk = 1'b1;
              state_d          = ST_NODE;
            end
          endcase
        end
      end
      ST_NODE: begin
        // node word is valid here; leaf test wins over the depth check
        if (stat_i.node_leaf) begin
          state_d = ST_EMIT;
        end else if (stat_i.depth_hit) begin
          state_d = ST_ERR;
        end else begin
          state_d = ST_CMP;
        end
      end
      ST_CMP: begin
        cmd_o.take_step = 1'b1;
        state_d         = ST_NODE;
      end
      ST_EMIT: begin
        if (stat_i.out_free) begin
          cmd_o.emit_class = 1'b1;
          if (stat_i.class_last) begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_ERR: begin
        if (stat_i.out_free) begin
          cmd_o.emit_error = 1'b1;
          state_d          = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  a_start_on_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.start_walk |-> (in_valid_i && in_ready_o))
    else $error("walk started without an accepted item");

  a_error_ends_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit_error |=> (state_q == ST_IDLE))
    else $error("error result did not end the walk");

endmodule

### sv/dtc_datapath.sv
// ----------------------------------------------------------------------------
// dtc_datapath
// Node, histogram and feature memories, walk registers, config and output
// register.
// ----------------------------------------------------------------------------
module dtc_datapath
  import dtc_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic [1:0]    cfg_idx_i,
  input  logic [7:0]    cfg_data_i,
  input  dtc_in_item_t  in_item_i,
  input  dtc_cmd_t      cmd_i,
  output dtc_stat_t     stat_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output dtc_out_item_t out_item_o
);

  // configuration
  logic [4:0] num_classes_q;
  logic [7:0] root_node_q;
  logic [7:0] depth_limit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_classes_q <= 5'd16;
      root_node_q   <= 8'd0;
      depth_limit_q <= 8'd255;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_NUM_CLASSES: num_classes_q <= cfg_data_i[4:0];
        CFG_ROOT_NODE:   root_node_q   <= cfg_data_i;
        CFG_DEPTH_LIMIT: depth_limit_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // class count clamped to 1..CLASSES
  logic [4:0] n_eff;
  always_comb begin
    if (num_classes_q == 5'd0) begin
      n_eff = 5'd1;
    end else if (num_classes_q > 5'(CLASSES)) begin
      n_eff = 5'(CLASSES);
    end else begin
      n_eff = num_classes_q;
    end
  end

  // walk registers
  logic [NODE_W-1:0]  cur_q, cur_d;
  logic [CLASS_W-1:0] class_q, class_d;
  logic [7:0]         steps_q, steps_d;

  dtc_node_t          node_rd_q;
  logic [31:0]        feat_rd_q;
  logic [16:0]        hist_rd_q;
  logic               go_left;

  assign go_left = $signed(feat_rd_q) < $signed(node_rd_q.thr);

  always_comb begin
    cur_d   = cur_q;
    class_d = class_q;
    steps_d = steps_q;
    if (cmd_i.start_walk) begin
      cur_d   = root_node_q[NODE_W-1:0];
      class_d = '0;
      steps_d = '0;
    end
    if (cmd_i.take_step) begin
      cur_d   = go_left ? node_rd_q.left[NODE_W-1:0] : node_rd_q.right[NODE_W-1:0];
      steps_d = steps_q + 8'd1;
    end
    if (cmd_i.emit_class) begin
      class_d = class_q + CLASS_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q   <= '0;
      class_q <= '0;
      steps_q <= '0;
    end else begin
      cur_q   <= cur_d;
      class_q <= class_d;
      steps_q <= steps_d;
    end
  end

  // memories: one write port, registered read; node and histogram reads take the
  // next-value signals to match the current walk registers, feature reads node_rd_q
  dtc_node_t   node_mem [NODES];
  logic [16:0] hist_mem [NODES*CLASSES];
  logic [31:0] feat_mem [FEATURES];

  dtc_node_t   node_wr;
  logic [16:0] prob_sat;
  logic        leaf_slot_ok;

  assign node_wr.feat  = in_item_i.split_feature;
  assign node_wr.thr   = in_item_i.split_threshold;
  assign node_wr.leaf  = in_item_i.is_leaf;
  assign node_wr.left  = in_item_i.left_child;
  assign node_wr.right = in_item_i.right_child;

  assign leaf_slot_ok = in_item_i.slot < 6'(CLASSES);

  always_comb begin
    if (in_item_i.sample_value[31]) begin
      prob_sat = '0;
    end else if (in_item_i.sample_value > 32'sd65536) begin
      prob_sat = PROB_ONE;
    end else begin
      prob_sat = in_item_i.sample_value[16:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_node) begin
      node_mem[in_item_i.node_addr[NODE_W-1:0]] <= node_wr;
    end
    node_rd_q <= node_mem[cur_d];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_leaf && leaf_slot_ok) begin
      hist_mem[{in_item_i.node_addr[NODE_W-1:0], in_item_i.slot[CLASS_W-1:0]}] <= prob_sat;
    end
    hist_rd_q <= hist_mem[{cur_d, class_d}];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_feat) begin
      feat_mem[in_item_i.slot[FEAT_W-1:0]] <= in_item_i.sample_value;
    end
    feat_rd_q <= feat_mem[node_rd_q.feat[FEAT_W-1:0]];
  end

  // output register
  logic          out_valid_q;
  dtc_out_item_t out_item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit_class || cmd_i.emit_error) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_class) begin
      out_item_q.class_index <= 4'(class_q);
      out_item_q.probability <= hist_rd_q;
      out_item_q.leaf_node   <= 8'(cur_q);
      out_item_q.status      <= 1'b0;
      out_item_q.last        <= stat_o.class_last;
    end else if (cmd_i.emit_error) begin
      out_item_q.class_index <= '0;
      out_item_q.probability <= '0;
      out_item_q.leaf_node   <= 8'(cur_q);
      out_item_q.status      <= 1'b1;
      out_item_q.last        <= 1'b1;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  assign stat_o.node_leaf  = node_rd_q.leaf;
  assign stat_o.depth_hit  = steps_q >= depth_limit_q;
  assign stat_o.class_last = ({1'b0, class_q} + 5'd1) == n_eff;
  assign stat_o.out_free   = !out_valid_q || out_ready_i;

  a_load_into_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.emit_class || cmd_i.emit_error) |-> (!out_valid_q || out_ready_i))
    else $error("result loaded over an untaken item");

  a_step_in_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.take_step |-> (steps_q < depth_limit_q))
    else $error("branch step taken past the depth limit");

  a_single_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_i.emit_class && cmd_i.emit_error))
    else $error("class and error result loaded together");

endmodule

### sv/decision_tree_classifier.sv
// ----------------------------------------------------------------------------
// decision_tree_classifier
// Decision tree inference: loads nodes, leaf histograms and features, then
// walks the tree from the root and emits the class probabilities of the leaf.
// ----------------------------------------------------------------------------
//  channel   dir  handshake      payload
//  item_i    in   valid/ready    dtc_in_item_t (mode, node, leaf prob, feature)
//  result_o  out  valid/ready    dtc_out_item_t (one item per class, or error)
//  cfg       in   cfg_we_i       cfg_idx_i selects register, cfg_data_i value
//
//  Write items are stored as they are accepted. A classify item walks d
//  branch steps then emits n class results, or stops with one error result at
//  the depth limit; a step is a node read then a feature read from the memories.
//  Results leave through a single output register; a stall holds emission.
//  Reset is asynchronous, active low; memory contents are not cleared.
// ----------------------------------------------------------------------------
module decision_tree_classifier
  import dtc_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  dtc_in_if.sink     item_i,
  dtc_out_if.source  result_o,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_idx_i,
  input  logic [7:0] cfg_data_i
);

  dtc_cmd_t  cmd;
  dtc_stat_t stat;

  dtc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (item_i.valid),
    .in_mode_i  (item_i.data.mode),
    .in_ready_o (item_i.ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  dtc_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_item_i   (item_i.data),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_valid_o (result_o.valid),
    .out_ready_i (result_o.ready),
    .out_item_o  (result_o.data)
  );

endmodule

### sim/dtc_result_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dtc_result_checker
// Watches the item, result and register ports of the decision tree
// classifier, keeps its own copy of the node, histogram and feature stores,
// walks the tree for every classify item and compares each result field.
// ----------------------------------------------------------------------------
module dtc_result_checker
  import dtc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  dtc_in_if           item_mon,
  dtc_out_if          result_mon,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [7:0]  cfg_data_i,
  output int unsigned results_owed_o,
  output int unsigned errors_o
);

  localparam int   CLASS_CAP    = (CLASSES < 16) ? CLASSES : 16;
  localparam logic STATUS_OK    = 1'b0;
  localparam logic STATUS_DEPTH = 1'b1;

  dtc_node_t     node_mem [NODES];
  logic [16:0]   prob_mem [NODES*CLASSES];
  logic [31:0]   feat_mem [FEATURES];
  logic [4:0]    classes_r;
  logic [7:0]    root_r;
  logic [7:0]    depth_r;
  dtc_out_item_t leaf_results_q [$];
  int unsigned   owed_cnt = 0;
  int unsigned   err_cnt  = 0;

  assign results_owed_o = owed_cnt;
  assign errors_o       = err_cnt;

  function automatic logic [16:0] clamp_prob(input logic [31:0] raw);
    if (raw[31]) return '0;
    if (raw > 32'(PROB_ONE)) return PROB_ONE;
    return raw[16:0];
  endfunction

  // walk from the root; either one depth error or one item per class
  task automatic walk_tree();
    logic [7:0]    cur;
    logic [31:0]   fval;
    int unsigned   steps;
    int unsigned   n;
    bit            aborted;
    dtc_out_item_t r;
    cur     = root_r;
    steps   = 0;
    aborted = 1'b0;
    while (!node_mem[cur].leaf && !aborted) begin
      fval = (node_mem[cur].feat < FEATURES) ? feat_mem[node_mem[cur].feat] : '0;
      if (steps >= depth_r) begin
        r.class_index = '0;
        r.probability = '0;
        r.leaf_node   = cur;
        r.status      = STATUS_DEPTH;
        r.last        = 1'b1;
        leaf_results_q = {leaf_results_q, r};
        aborted = 1'b1;
      end else begin
        steps++;
        cur = ($signed(fval) < $signed(node_mem[cur].thr)) ? node_mem[cur].left
                                                           : node_mem[cur].right;
      end
    end
    if (!aborted) begin
      n = classes_r;
      if (n < 1) n = 1;
      if (n > CLASS_CAP) n = CLASS_CAP;
      for (int c = 0; c < n; c++) begin
        r.class_index = 4'(c);
        r.probability = prob_mem[{cur, 4'(c)}];
        r.leaf_node   = cur;
        r.status      = STATUS_OK;
        r.last        = (c + 1 == n);
        leaf_results_q = {leaf_results_q, r};
      end
    end
  endtask

  task automatic apply_item(input dtc_in_item_t it);
    case (dtc_mode_e'(it.mode))
      MODE_NODE: begin
        node_mem[it.node_addr].feat  = it.split_feature;
        node_mem[it.node_addr].thr   = it.split_threshold;
        node_mem[it.node_addr].leaf  = it.is_leaf;
        node_mem[it.node_addr].left  = it.left_child;
        node_mem[it.node_addr].right = it.right_child;
      end
      MODE_LEAF: begin
        // class slots beyond the histogram are dropped
        if (it.slot < CLASSES) prob_mem[{it.node_addr, it.slot[3:0]}] = clamp_prob(it.sample_value);
      end
      MODE_FEAT: begin
        if (it.slot < FEATURES) feat_mem[it.slot] = it.sample_value;
      end
      default: walk_tree();
    endcase
  endtask

  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      err_cnt++;
    end
  endtask

  task automatic check_result(input dtc_out_item_t got);
    dtc_out_item_t want;
    if (leaf_results_q.size() == 0) begin
      $error("result item with nothing pending: class_index %0d leaf_node %0d status %0d",
             got.class_index, got.leaf_node, got.status);
      err_cnt++;
    end else begin
      want = leaf_results_q.pop_front();
      check_field("class_index", want.class_index, got.class_index);
      check_field("probability", want.probability, got.probability);
      check_field("leaf_node", want.leaf_node, got.leaf_node);
      check_field("status", want.status, got.status);
      check_field("last", want.last, got.last);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      classes_r = 5'd16;
      root_r    = 8'd0;
      depth_r   = 8'd255;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_NUM_CLASSES: classes_r = cfg_data_i[4:0];
          CFG_ROOT_NODE:   root_r    = cfg_data_i;
          CFG_DEPTH_LIMIT: depth_r   = cfg_data_i;
          default: ;
        endcase
      end
      if (result_mon.valid && result_mon.ready) check_result(result_mon.data);
      if (item_mon.valid && item_mon.ready) apply_item(item_mon.data);
      owed_cnt = leaf_results_q.size();
    end
  end

endmodule

### sim/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Loads small random trees into the decision tree classifier and classifies
// against them under several register settings, with random gaps on both
// channels; the checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb;
  import dtc_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT  = 4000;
  localparam int unsigned HOLD_OFF_CYCLES = 300;
  localparam int unsigned SETTLE_CYCLES   = 8;
  localparam int unsigned TAIL_CYCLES     = 60;
  localparam int unsigned PHASE_ITEMS     = 33;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [1:0]  cfg_idx;
  logic [7:0]  cfg_data;
  int unsigned results_owed;
  int unsigned check_errors;
  int unsigned idle_cycles  = 0;
  int unsigned results_seen = 0;

  dtc_in_if  item_ch ();
  dtc_out_if result_ch ();

  decision_tree_classifier u_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .item_i     (item_ch),
    .result_o   (result_ch),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  dtc_result_checker u_checker (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .item_mon       (item_ch),
    .result_mon     (result_ch),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_data_i     (cfg_data),
    .results_owed_o (results_owed),
    .errors_o       (check_errors)
  );

  initial clk = 1'b0;
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // watchdog on cycles with no item moving on either channel
  always @(posedge clk) begin
    if (result_ch.valid && result_ch.ready) results_seen <= results_seen + 1;
    if (!rst_n || (item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("decision_tree_classifier test failed");
        $finish;
      end
    end
  end

  // result side: random ready pattern, one long hold-off after 150 results are taken
  initial begin : receiver
    int unsigned run;
    int unsigned gap;
    int unsigned roll;
    bit          held;
    result_ch.ready = 1'b0;
    held = 1'b0;
    @(posedge rst_n);
    forever begin
      if (!held && results_seen >= 150) begin
        held = 1'b1;
        @(negedge clk);
        result_ch.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(negedge clk);
      end
      roll = $urandom_range(0, 99);
      run  = (roll < 85) ? $urandom_range(1, 20) : $urandom_range(60, 120);
      @(negedge clk);
      result_ch.ready <= 1'b1;
      repeat (run - 1) @(negedge clk);
      roll = $urandom_range(0, 99);
      if (roll < 50)      gap = 0;
      else if (roll < 85) gap = $urandom_range(1, 3);
      else if (roll < 95) gap = $urandom_range(4, 10);
      else                gap = $urandom_range(10, 40);
      if (gap != 0) begin
        @(negedge clk);
        result_ch.ready <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
  end

  // stimulus bookkeeping: only written entries may ever be reached by a walk
  bit          node_seen [NODES];
  bit          probs_full [NODES];
  bit          feat_seen [FEATURES];
  logic [31:0] feat_val  [FEATURES];
  logic [7:0]  node_pool [$];
  logic [7:0]  leaf_pool [$];
  logic [5:0]  feat_pool [$];
  int unsigned items_sent = 0;

  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    if (roll < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 50);
  endfunction

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 7))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'h0000_0000;
      3:       return 32'($urandom_range(0, 131071)) - 32'd65536;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] rand_prob();
    case ($urandom_range(0, 9))
      0:       return $urandom;
      1:       return 32'(PROB_ONE);
      2:       return 32'(PROB_ONE) + 32'($urandom_range(1, 1000));
      default: return 32'($urandom_range(0, 65536));
    endcase
  endfunction

  function automatic dtc_in_item_t junk_item(input dtc_mode_e m);
    dtc_in_item_t it;
    it.mode            = m;
    it.node_addr       = 8'($urandom);
    it.split_feature   = 6'($urandom);
    it.split_threshold = $urandom;
    it.is_leaf         = 1'($urandom);
    it.left_child      = 8'($urandom);
    it.right_child     = 8'($urandom);
    it.slot            = 6'($urandom);
    it.sample_value    = $urandom;
    return it;
  endfunction

  function automatic logic [7:0] pick_node();
    return node_pool[$urandom_range(0, node_pool.size() - 1)];
  endfunction

  task automatic send_item(input dtc_in_item_t it);
    int unsigned gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap != 0) begin
      item_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    item_ch.valid <= 1'b1;
    item_ch.data  <= it;
    do @(posedge clk); while (!item_ch.ready);
    items_sent++;
  endtask

  task automatic write_feature(input logic [5:0] slot, input logic [31:0] val);
    dtc_in_item_t it;
    it = junk_item(MODE_FEAT);
    it.slot         = slot;
    it.sample_value = val;
    send_item(it);
    feat_val[slot] = val;
    if (!feat_seen[slot]) begin
      feat_seen[slot] = 1'b1;
      feat_pool = {feat_pool, slot};
    end
  endtask

  task automatic write_prob(input logic [7:0] addr, input logic [5:0] slot,
                            input logic [31:0] val);
    dtc_in_item_t it;
    it = junk_item(MODE_LEAF);
    it.node_addr    = addr;
    it.slot         = slot;
    it.sample_value = val;
    send_item(it);
  endtask

  task automatic write_node(input logic [7:0] addr, input logic [5:0] feat,
                            input logic [31:0] thr, input logic leaf,
                            input logic [7:0] left, input logic [7:0] right);
    dtc_in_item_t it;
    it = junk_item(MODE_NODE);
    it.node_addr       = addr;
    it.split_feature   = feat;
    it.split_threshold = thr;
    it.is_leaf         = leaf;
    it.left_child      = left;
    it.right_child     = right;
    send_item(it);
    if (!node_seen[addr]) begin
      node_seen[addr] = 1'b1;
      node_pool = {node_pool, addr};
    end
  endtask

  // every class of a leaf is written before the leaf itself
  task automatic put_leaf(input logic [7:0] addr, input bit corner_vals);
    logic [31:0] pv;
    if (!probs_full[addr]) begin
      for (int c = 0; c < CLASSES; c++) begin
        pv = rand_prob();
        if (corner_vals) begin
          case (c)
            0: pv = 32'hFFFF_FFFF;
            1: pv = 32'(PROB_ONE);
            2: pv = 32'(PROB_ONE) + 32'd1;
            3: pv = 32'h7FFF_FFFF;
            4: pv = 32'h8000_0000;
            5: pv = 32'd0;
            default: ;
          endcase
        end
        write_prob(addr, 6'(c), pv);
      end
      probs_full[addr] = 1'b1;
      leaf_pool = {leaf_pool, addr};
    end
    write_node(addr, 6'($urandom), $urandom, 1'b1, 8'($urandom), 8'($urandom));
  endtask

  task automatic classify();
    send_item(junk_item(MODE_CLASSIFY));
  endtask

  // wait until every owed result has left, then let the block settle
  task automatic drain();
    @(negedge clk);
    item_ch.valid <= 1'b0;
    while (results_owed != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we   <= 1'b0;
  endtask

  task automatic set_config(input logic [4:0] classes, input logic [7:0] root,
                            input logic [7:0] depth);
    drain();
    write_reg(CFG_NUM_CLASSES, 8'(classes));
    write_reg(CFG_ROOT_NODE, root);
    write_reg(CFG_DEPTH_LIMIT, depth);
  endtask

  task automatic random_item();
    int unsigned roll;
    logic [7:0]  addr;
    logic [5:0]  f;
    logic [31:0] thr;
    int unsigned pick;
    logic [7:0]  kids [2];
    roll = $urandom_range(0, 99);
    if (roll < 30) begin
      classify();
    end else if (roll < 45) begin
      write_feature(6'($urandom), rand_word());
    end else if (roll < 65) begin
      addr = 8'($urandom);
      f    = feat_pool[$urandom_range(0, feat_pool.size() - 1)];
      // half the thresholds sit within one of the feature so both branches are taken
      thr  = ($urandom_range(0, 1) != 0) ? feat_val[f] + 32'($urandom_range(0, 2)) - 32'd1
                                         : rand_word();
      for (int k = 0; k < 2; k++) begin
        pick    = $urandom_range(0, node_pool.size());
        kids[k] = (pick == node_pool.size()) ? addr : node_pool[pick];
      end
      write_node(addr, f, thr, 1'b0, kids[0], kids[1]);
    end else if (roll < 80) begin
      if (leaf_pool.size() < 6 || $urandom_range(0, 9) == 0) addr = 8'($urandom);
      else addr = leaf_pool[$urandom_range(0, leaf_pool.size() - 1)];
      put_leaf(addr, 1'b0);
    end else if (roll < 95) begin
      // class slots above the histogram are dropped by the block
      write_prob(leaf_pool[$urandom_range(0, leaf_pool.size() - 1)], 6'($urandom), rand_prob());
    end else begin
      write_prob(8'($urandom), 6'($urandom), $urandom);
    end
  endtask

  initial begin : stimulus
    int unsigned target;
    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_idx       = CFG_NUM_CLASSES;
    cfg_data      = '0;
    item_ch.valid = 1'b0;
    item_ch.data  = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: extreme features, saturating probabilities, both branch senses
    write_feature(6'd0, 32'h7FFF_FFFF);
    write_feature(6'd63, 32'h8000_0000);
    put_leaf(8'd255, 1'b1);
    write_prob(8'd255, 6'd63, 32'd1234);
    // feature equal to threshold goes right to the leaf
    write_node(8'd0, 6'd63, 32'h8000_0000, 1'b0, 8'd0, 8'd255);
    classify();
    // feature below threshold loops on itself until the depth limit trips
    write_node(8'd0, 6'd63, 32'h7FFF_FFFF, 1'b0, 8'd0, 8'd255);
    classify();
    // zero classes saturates to one; root leaf needs no branch step
    set_config(5'd0, 8'd255, 8'd0);
    classify();
    // depth limit zero aborts on a branch root straight away
    set_config(5'd31, 8'd0, 8'd0);
    classify();

    for (int p = 0; p < 6; p++) begin
      case (p)
        0:       set_config(5'd16, pick_node(), 8'd255);
        1:       set_config(5'd1, 8'd255, 8'd1);
        2:       set_config(5'd17, pick_node(), 8'd3);
        3:       set_config(5'($urandom_range(1, 16)), pick_node(), 8'($urandom_range(1, 8)));
        4:       set_config(5'd5, pick_node(), 8'd255);
        default: set_config(5'($urandom_range(1, 16)), pick_node(), 8'd2);
      endcase
      target = items_sent + PHASE_ITEMS;
      while (items_sent < target) random_item();
    end

    drain();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (check_errors == 0 && results_owed == 0) begin
      $display("decision_tree_classifier test passed");
    end else begin
      $display("decision_tree_classifier test failed");
    end
    $finish;
  end

endmodule

### files.f
sv/dtc_pkg.sv
sv/dtc_in_if.sv
sv/dtc_out_if.sv
sv/dtc_ctrl.sv
sv/dtc_datapath.sv
sv/decision_tree_classifier.sv
sim/dtc_result_checker.sv
sim/tb.sv
